/* sv/spdi_variant_parser_core_macros.svh */
// Assertion macros for the port-level checker of the SPDI parser.
// Depends on nothing; each file that asserts includes it by name.
`ifndef SPDI_VARIANT_PARSER_CORE_MACROS_SVH
`define SPDI_VARIANT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define SPDI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spdi check failed");

// Next-cycle implication, checked during reset as well.
`define SPDI_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spdi check failed");

// Next-cycle implication, ignored while reset is held.
`define SPDI_ASSERT_NXT_RST(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spdi check failed");

`endif

/* sv/spdi_pkg.sv */
// Shared types for the SPDI variant parser.
// Used by spdi_char_class and spdi_variant_parser_core; depends on nothing.
`timescale 1ns / 1ps

package spdi_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;

  // Classification of one input character.
  typedef struct packed {
    logic       is_colon;
    logic       is_dec;
    logic       is_base;
    logic [3:0] digit;
  } char_class_t;

endpackage

/* sv/spdi_char_class.sv */
// Character classifier: colon, decimal digit with its value, nucleotide letter.
// Depends on spdi_pkg.
`timescale 1ns / 1ps

module spdi_char_class (
  input  logic [7:0]           char_in,
  output spdi_pkg::char_class_t cls
);

  always_comb begin
    cls.is_colon = (char_in == spdi_pkg::CH_COLON);
    cls.is_dec   = (char_in >= spdi_pkg::CH_ZERO) && (char_in <= spdi_pkg::CH_NINE);
    cls.is_base  = (char_in == spdi_pkg::CH_A) || (char_in == spdi_pkg::CH_C) ||
                   (char_in == spdi_pkg::CH_G) || (char_in == spdi_pkg::CH_T);
    // ASCII digits sit at 0x30..0x39, so the low nibble is the value.
    cls.digit    = char_in[3:0];
  end

endmodule

/* sv/spdi_variant_parser_core.sv */
// SPDI variant expression parser, top level.
// Depends on spdi_pkg and spdi_char_class.
// Usage:
//   The input channel (in_valid, in_stall, in_char_in, in_is_final) carries
//   one ASCII character of an expression "id:start:deleted:inserted" per
//   request; in_is_final marks the last character of the expression.
//   The result channel (out_valid, out_stall, out_valid_res, out_start_pos,
//   out_end_pos, out_ins_offset, out_ins_length) carries one request per
//   expression, issued for its final character. An invalid expression gives
//   out_valid_res = 0 with all other result fields zero.
//   Throughput is one character per cycle while in_stall is low: a character
//   waits in the input register, and the parser state, plus the result register
//   for a final character, update as it drains, using two 32-bit multiply-by-ten
//   adds and one 32-bit end-position add. The result register drives out_valid;
//   a final character waits while an earlier result is still held by out_stall.
//   While out_stall holds a result, characters that are not final still flow
//   into the parser; a final character waits in the input register, and
//   in_stall rises once that register cannot drain.
//   Synchronous active-low reset empties both registers and clears the parser;
//   after each final character the parser also restarts in the identifier phase.
`timescale 1ns / 1ps

module spdi_variant_parser_core #(
  parameter longint unsigned MAX_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [31:0] out_start_pos,
  output logic [31:0] out_end_pos,
  output logic [15:0] out_ins_offset,
  output logic [15:0] out_ins_length
);

  localparam int CNT_W = $clog2(MAX_LEN + 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  typedef enum logic [1:0] {
    PH_IDENT,
    PH_START,
    PH_DEL,
    PH_INS
  } phase_t;

  // Input register.
  logic             s1_valid_r;
  logic [7:0]       s1_char_r;
  logic             s1_final_r;

  // Parser state.
  phase_t           phase_r,  phase_nxt;
  logic             failed_r, failed_nxt;
  logic [31:0]      start_r,  start_nxt;
  logic [31:0]      del_r,    del_nxt;
  logic             del_num_r, del_num_nxt;
  logic [CNT_W-1:0] fcnt_r,   fcnt_nxt;
  logic [CNT_W-1:0] cpos_r,   cpos_nxt;
  logic [CNT_W-1:0] ins_beg_r, ins_beg_nxt;

  // Result register.
  logic             out_valid_r;
  logic             res_ok_r;
  logic [31:0]      res_start_r, res_end_r;
  logic [15:0]      res_off_r, res_len_r;

  spdi_pkg::char_class_t cls;
  logic                  advance;
  logic                  s1_load;
  logic                  res_ok;
  logic [CNT_W-1:0]      fcnt_inc;
  logic [CNT_W-1:0]      cpos_inc;
  logic [31:0]           start_mac;
  logic [31:0]           del_mac;

  spdi_char_class u_class (
    .char_in (s1_char_r),
    .cls     (cls)
  );

  // A character that is not final never needs the result register.
  assign advance  = s1_valid_r && (!s1_final_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign s1_load  = in_valid && !in_stall;

  assign fcnt_inc  = (fcnt_r < CNT_MAX) ? fcnt_r + CNT_W'(1) : fcnt_r;
  assign cpos_inc  = (cpos_r < CNT_MAX) ? cpos_r + CNT_W'(1) : cpos_r;
  assign start_mac = (start_r << 3) + (start_r << 1) + 32'(cls.digit);
  assign del_mac   = (del_r << 3) + (del_r << 1) + 32'(cls.digit);

  always_comb begin
    phase_nxt   = phase_r;
    failed_nxt  = failed_r;
    start_nxt   = start_r;
    del_nxt     = del_r;
    del_num_nxt = del_num_r;
    fcnt_nxt    = fcnt_r;
    ins_beg_nxt = ins_beg_r;
    cpos_nxt    = cpos_inc;
    if (!failed_r) begin
      unique case (phase_r)
        PH_IDENT: begin
          if (cls.is_colon) begin
            phase_nxt = PH_START;
            fcnt_nxt  = '0;
          end
        end
        PH_START: begin
          if (cls.is_dec) begin
            start_nxt = start_mac;
            fcnt_nxt  = fcnt_inc;
          end else if (cls.is_colon && (fcnt_r != '0)) begin
            phase_nxt   = PH_DEL;
            fcnt_nxt    = '0;
            del_nxt     = '0;
            del_num_nxt = 1'b0;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_DEL: begin
          if (cls.is_colon) begin
            // A letter run is counted; its length becomes the deleted count.
            if (!del_num_r) begin
              del_nxt = 32'(fcnt_r);
            end
            phase_nxt   = PH_INS;
            fcnt_nxt    = '0;
            ins_beg_nxt = cpos_inc;
          end else if (cls.is_dec && ((fcnt_r == '0) || del_num_r)) begin
            del_num_nxt = 1'b1;
            del_nxt     = del_mac;
            fcnt_nxt    = fcnt_inc;
          end else if (cls.is_base && !del_num_r) begin
            fcnt_nxt = fcnt_inc;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_INS: begin
          if (cls.is_base) begin
            fcnt_nxt = fcnt_inc;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  assign res_ok = !failed_nxt && (phase_nxt == PH_INS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_IDENT;
      failed_r    <= 1'b0;
      start_r     <= '0;
      del_r       <= '0;
      del_num_r   <= 1'b0;
      fcnt_r      <= '0;
      cpos_r      <= '0;
      ins_beg_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
        s1_char_r  <= in_char_in;
        s1_final_r <= in_is_final;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance && s1_final_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        if (s1_final_r) begin
          // Final character: issue the result and start over.
          res_ok_r    <= res_ok;
          res_start_r <= res_ok ? start_nxt : '0;
          res_end_r   <= res_ok ? start_nxt + del_nxt : '0;
          res_off_r   <= res_ok ? 16'(ins_beg_nxt) : '0;
          res_len_r   <= res_ok ? 16'(fcnt_nxt) : '0;
          phase_r     <= PH_IDENT;
          failed_r    <= 1'b0;
          start_r     <= '0;
          del_r       <= '0;
          del_num_r   <= 1'b0;
          fcnt_r      <= '0;
          cpos_r      <= '0;
          ins_beg_r   <= '0;
        end else begin
          phase_r   <= phase_nxt;
          failed_r  <= failed_nxt;
          start_r   <= start_nxt;
          del_r     <= del_nxt;
          del_num_r <= del_num_nxt;
          fcnt_r    <= fcnt_nxt;
          cpos_r    <= cpos_nxt;
          ins_beg_r <= ins_beg_nxt;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_ok_r;
  assign out_start_pos  = res_start_r;
  assign out_end_pos    = res_end_r;
  assign out_ins_offset = res_off_r;
  assign out_ins_length = res_len_r;

endmodule

/* sv/spdi_checker.sv */
// Port-level checks for the SPDI parser, bound to its top level.
// Depends on spdi_variant_parser_core_macros.svh.
`timescale 1ns / 1ps
`include "spdi_variant_parser_core_macros.svh"

module spdi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_valid_res,
  input logic [31:0] out_start_pos,
  input logic [31:0] out_end_pos,
  input logic [15:0] out_ins_offset,
  input logic [15:0] out_ins_length
);

  logic [96:0] out_payload;
  logic        out_held;
  logic        out_fields_zero;

  assign out_payload = {out_valid_res, out_start_pos, out_end_pos, out_ins_offset,
                        out_ins_length};
  assign out_held    = out_valid && out_stall;
  assign out_fields_zero = (out_start_pos == 32'd0) && (out_end_pos == 32'd0) &&
                           (out_ins_offset == 16'd0) && (out_ins_length == 16'd0);

  // A stalled result request stays up with the same payload.
  `SPDI_ASSERT_NXT_RST(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_payload))

  // A failed parse reports all result fields as zero.
  `SPDI_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_valid_res, out_fields_zero)

  // Reset leaves no result pending and the input side open.
  `SPDI_ASSERT_NXT(a_reset_clear, clk, !rst_n, !out_valid && !in_stall)

  // The input side only backs up behind a stalled result.
  `SPDI_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_held)

endmodule

bind spdi_variant_parser_core spdi_checker u_spdi_checker (.*);

/* dv/spdi_variant_parser_checker.sv */
// Checker for the SPDI variant parser: watches both channels and predicts every result.
// Depends on spdi_pkg for the character constants.
`timescale 1ns / 1ps

module spdi_variant_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_is_final,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_valid_res,
  input  logic [31:0] out_start_pos,
  input  logic [31:0] out_end_pos,
  input  logic [15:0] out_ins_offset,
  input  logic [15:0] out_ins_length,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          valid_count
);

  localparam logic [15:0] MAX_LEN = 16'hFFFF;

  typedef enum logic [1:0] {PH_IDENT, PH_START, PH_DEL, PH_INS} parse_phase_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [15:0] ins_offset;
    logic [15:0] ins_length;
  } spdi_result_t;

  parse_phase_t phase;
  logic         failed;
  logic [31:0]  start_acc;
  logic [31:0]  del_acc;
  logic         del_is_count;
  logic [15:0]  field_cnt;
  logic [15:0]  char_pos;
  logic [15:0]  ins_begin;

  spdi_result_t expected_results[$];

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v < MAX_LEN) ? v + 16'd1 : v;
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= spdi_pkg::CH_ZERO) && (c <= spdi_pkg::CH_NINE);
  endfunction

  function automatic logic is_base(input logic [7:0] c);
    return (c == spdi_pkg::CH_A) || (c == spdi_pkg::CH_C) ||
           (c == spdi_pkg::CH_G) || (c == spdi_pkg::CH_T);
  endfunction

  task automatic clear_parser();
    phase        = PH_IDENT;
    failed       = 1'b0;
    start_acc    = '0;
    del_acc      = '0;
    del_is_count = 1'b0;
    field_cnt    = '0;
    char_pos     = '0;
    ins_begin    = '0;
  endtask

  task automatic advance_parser(input logic [7:0] c, input logic fin);
    logic         colon;
    logic [31:0]  digit;
    spdi_result_t res;
    colon = (c == spdi_pkg::CH_COLON);
    digit = {24'h0, c - spdi_pkg::CH_ZERO};
    if (!failed) begin
      case (phase)
        PH_IDENT: begin
          if (colon) begin
            phase     = PH_START;
            field_cnt = '0;
          end
        end
        PH_START: begin
          if (is_dec_char(c)) begin
            start_acc = start_acc * 32'd10 + digit;
            field_cnt = sat_inc(field_cnt);
          end else if (colon && field_cnt != 16'd0) begin
            phase        = PH_DEL;
            field_cnt    = '0;
            del_acc      = '0;
            del_is_count = 1'b0;
          end else begin
            failed = 1'b1;
          end
        end
        PH_DEL: begin
          if (colon) begin
            // A letter run is measured by its length rather than its value.
            if (!del_is_count) del_acc = {16'h0, field_cnt};
            phase     = PH_INS;
            field_cnt = '0;
            ins_begin = sat_inc(char_pos);
          end else if (is_dec_char(c) && (field_cnt == 16'd0 || del_is_count)) begin
            del_is_count = 1'b1;
            del_acc      = del_acc * 32'd10 + digit;
            field_cnt    = sat_inc(field_cnt);
          end else if (is_base(c) && !del_is_count) begin
            field_cnt = sat_inc(field_cnt);
          end else begin
            failed = 1'b1;
          end
        end
        PH_INS: begin
          if (is_base(c)) field_cnt = sat_inc(field_cnt);
          else failed = 1'b1;
        end
      endcase
    end
    char_pos = sat_inc(char_pos);
    if (fin) begin
      res = '0;
      if (!failed && phase == PH_INS) begin
        res.valid_res  = 1'b1;
        res.start_pos  = start_acc;
        res.end_pos    = start_acc + del_acc;
        res.ins_offset = ins_begin;
        res.ins_length = field_cnt;
      end
      expected_results.push_back(res);
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: result %0d, %s expected 0x%0h, got 0x%0h",
               $time, checked_count, name, exp_v, act_v);
    end
  endtask

  initial begin
    clear_parser();
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    valid_count   = 0;
  end

  // Results are checked before the character of the same edge is predicted, so a
  // result never meets an expectation that was created on its own edge.
  always @(posedge clk) begin
    spdi_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got valid_res=%0b start=0x%0h",
                   $time, out_valid_res, out_start_pos);
        end else begin
          exp_r = expected_results.pop_front();
          check_field("valid_res", {31'h0, exp_r.valid_res}, {31'h0, out_valid_res});
          check_field("start_pos", exp_r.start_pos, out_start_pos);
          check_field("end_pos", exp_r.end_pos, out_end_pos);
          check_field("ins_offset", {16'h0, exp_r.ins_offset}, {16'h0, out_ins_offset});
          check_field("ins_length", {16'h0, exp_r.ins_length}, {16'h0, out_ins_length});
          checked_count++;
          if (exp_r.valid_res) valid_count++;
        end
      end
      if (in_valid && !in_stall) advance_parser(in_char_in, in_is_final);
      pending = expected_results.size();
    end
  end

endmodule

/* dv/tb_spdi_variant_parser_core.sv */
// Testbench top for the SPDI variant parser: clock, reset, character stimulus and verdict.
// Depends on spdi_pkg, spdi_variant_parser_core and spdi_variant_parser_checker.
`timescale 1ns / 1ps

module tb_spdi_variant_parser_core;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 1850;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_in;
  logic        in_is_final;
  logic        out_valid;
  logic        out_stall;
  logic        out_valid_res;
  logic [31:0] out_start_pos;
  logic [31:0] out_end_pos;
  logic [15:0] out_ins_offset;
  logic [15:0] out_ins_length;

  int fail_count;
  int pending;
  int checked_count;
  int valid_count;
  int chars_sent;
  int exprs_sent;
  int cycle_count;
  int random_base;
  bit random_phase;

  logic [7:0] expr_chars[$];

  spdi_variant_parser_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_in    (in_char_in),
    .in_is_final   (in_is_final),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_start_pos (out_start_pos),
    .out_end_pos   (out_end_pos),
    .out_ins_offset(out_ins_offset),
    .out_ins_length(out_ins_length)
  );

  spdi_variant_parser_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_in    (in_char_in),
    .in_is_final   (in_is_final),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_start_pos (out_start_pos),
    .out_end_pos   (out_end_pos),
    .out_ins_offset(out_ins_offset),
    .out_ins_length(out_ins_length),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .valid_count   (valid_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    logic [7:0] d;
    repeat (n) begin
      d = spdi_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      expr_chars.push_back(d);
    end
  endtask

  task automatic push_bases(input int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: b = spdi_pkg::CH_A;
        1: b = spdi_pkg::CH_C;
        2: b = spdi_pkg::CH_G;
        default: b = spdi_pkg::CH_T;
      endcase
      expr_chars.push_back(b);
    end
  endtask

  // Identifier bytes may be anything but the field separator.
  task automatic push_ident(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == spdi_pkg::CH_COLON);
      expr_chars.push_back(b);
    end
  endtask

  task automatic make_random_expr();
    int n;
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 10);
      repeat (n) expr_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      push_ident($urandom_range(0, 5));
      expr_chars.push_back(spdi_pkg::CH_COLON);
      if ($urandom_range(0, 4) == 0) push_text("4294967295");
      else push_digits($urandom_range(1, 12));
      expr_chars.push_back(spdi_pkg::CH_COLON);
      case ($urandom_range(0, 2))
        0: ;
        1: push_digits($urandom_range(1, 11));
        default: push_bases($urandom_range(1, 8));
      endcase
      expr_chars.push_back(spdi_pkg::CH_COLON);
      push_bases($urandom_range(0, 8));
      // Break some of the well-formed expressions on purpose.
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 2))
          0: expr_chars[$urandom_range(0, expr_chars.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            n = $urandom_range(1, expr_chars.size() - 1);
            while (expr_chars.size() > n) void'(expr_chars.pop_back());
          end
          default: expr_chars.insert($urandom_range(0, expr_chars.size()), spdi_pkg::CH_COLON);
        endcase
      end
    end
  endtask

  // Sends the buffered expression one request per character, final flag on the last.
  task automatic send_expression(input bit no_gaps);
    int gap;
    bit burst;
    burst = no_gaps || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < expr_chars.size(); i++) begin
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid    <= 1'b1;
      in_char_in  <= expr_chars[i];
      in_is_final <= (i == expr_chars.size() - 1);
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      chars_sent++;
    end
    exprs_sent++;
    expr_chars.delete();
  endtask

  // Result side: random stall segments, plus one long hold-off once the random
  // traffic starts so that the block backs up into its input.
  initial begin
    int  seg_left;
    bit  stall_seg;
    bit  hold_done;
    seg_left  = 0;
    stall_seg = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (random_phase && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          stall_seg = ($urandom_range(0, 2) == 0);
          seg_left  = pick_gap() + 1;
        end
        out_stall <= stall_seg;
        seg_left--;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_in   = 8'h00;
    in_is_final  = 1'b0;
    out_stall    = 1'b0;
    random_phase = 1'b0;
    chars_sent   = 0;
    exprs_sent   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed expressions: valid forms, each kind of deleted field, wrapping
    // values, and every way an expression can fail.
    push_text("N:5::");                   send_expression(1'b0);
    push_text(":0:3:A");                  send_expression(1'b0);
    push_text("chr1:12:ACGT:TTG");        send_expression(1'b0);
    push_text("x::1:A");                  send_expression(1'b0);
    push_text("x:12:3A:C");               send_expression(1'b0);
    push_text("x:12:G7:C");               send_expression(1'b0);
    push_text("x:1:A:C:G");               send_expression(1'b0);
    push_text("x:1:A");                   send_expression(1'b0);
    push_text("x:1Z:1:A");                send_expression(1'b0);
    push_text("x:7:1:a");                 send_expression(1'b0);
    push_text("x:4294967295:1:");         send_expression(1'b0);
    push_text("x:99999999999:4294967295:"); send_expression(1'b0);
    push_text(":");                       send_expression(1'b0);
    expr_chars.push_back(8'hFF);          send_expression(1'b0);
    expr_chars.push_back(8'h00);
    push_text(":1::");                    send_expression(1'b1);

    random_phase = 1'b1;
    random_base  = chars_sent;
    while (chars_sent - random_base < RANDOM_CHARS) begin
      make_random_expr();
      send_expression(1'b0);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d expressions in %0d characters; checked %0d results, %0d valid.",
             exprs_sent, chars_sent, checked_count, valid_count);
    $display("Traffic mixed well-formed and broken expressions with a long result hold-off.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
